// ===== rtl/lhts_pkg.sv =====
// ----------------------------------------------------------------------------
// lhts_pkg
// Shared types and constants for the latency histogram / top-N stats block.
// ----------------------------------------------------------------------------
package lhts_pkg;

    localparam int NUM_BOUNDS    = 7;
    localparam int NUM_BINS      = 8;
    localparam int TOP_DEPTH_DEF = 8;
    localparam int ADDR_W        = 5;
    localparam int CFG_IDX_W     = 3;

    localparam logic [31:0] BOUND_RESET [NUM_BOUNDS] = '{
        32'd10, 32'd20, 32'd30, 32'd40, 32'd50, 32'd100, 32'd200
    };

    // request kinds
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // read groups
    localparam logic [1:0] GRP_BIN   = 2'd0;
    localparam logic [1:0] GRP_TOP   = 2'd1;
    localparam logic [1:0] GRP_TOTAL = 2'd2;

    // totals selectors
    localparam logic [5:0] TOT_CALLS  = 6'd0;
    localparam logic [5:0] TOT_ERRORS = 6'd1;
    localparam logic [5:0] TOT_SUM    = 6'd2;
    localparam logic [5:0] TOT_RECENT = 6'd3;

    typedef struct packed {
        logic        req_type;
        logic [15:0] access_id;
        logic [31:0] latency;
        logic        failed;
        logic [1:0]  read_group;
        logic [5:0]  read_index;
    } t_in_word;

    typedef struct packed {
        logic [63:0] read_value;
        logic [15:0] entry_id;
        logic [31:0] entry_latency;
        logic        entry_valid;
    } t_out_word;

    // one slot of the top-N row
    typedef struct packed {
        logic        valid;
        logic [15:0] id;
        logic [31:0] lat;
    } t_entry;

    typedef struct packed {
        logic [63:0] calls;
        logic [63:0] errors;
        logic [63:0] sum;
        logic [15:0] recent_id;
        logic [31:0] recent_lat;
    } t_totals;

endpackage

// ===== rtl/lhts_cell.sv =====
// ----------------------------------------------------------------------------
// lhts_cell
// One slot of the descending top-N row: keep, take the new word, or shift.
// ----------------------------------------------------------------------------
module lhts_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [15:0]     i_id,
    input  logic [31:0]     i_lat,
    input  logic            i_prev_take,
    input  lhts_pkg::t_entry i_prev_entry,
    output logic            o_take,
    output lhts_pkg::t_entry o_entry
);
    import lhts_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // new word belongs at or above this slot (strictly larger keeps ties stable)
    assign o_take  = !r_entry.valid || (r_entry.lat < i_lat);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_en && o_take) begin
            if (i_prev_take) begin
                n_entry = i_prev_entry;
            end else begin
                n_entry.valid = 1'b1;
                n_entry.id    = i_id;
                n_entry.lat   = i_lat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.id  <= n_entry.id;
        r_entry.lat <= n_entry.lat;
    end

endmodule

// ===== rtl/lhts_topn.sv =====
// ----------------------------------------------------------------------------
// lhts_topn
// Row of top-N cells with rank read-out.
// ----------------------------------------------------------------------------
module lhts_topn #(
    parameter int DEPTH = lhts_pkg::TOP_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ins_en,
    input  logic [15:0]      i_id,
    input  logic [31:0]      i_lat,
    input  logic [5:0]       i_rank,
    output lhts_pkg::t_entry o_entry
);
    import lhts_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_entry w_entry [DEPTH];
    logic   w_take  [DEPTH];
    t_entry w_sel;
    logic   w_in_range;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            lhts_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_en         (i_ins_en),
                .i_id         (i_id),
                .i_lat        (i_lat),
                .i_prev_take  (1'b0),
                .i_prev_entry ('0),
                .o_take       (w_take[g]),
                .o_entry      (w_entry[g])
            );
        end else begin : g_body
            lhts_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_en         (i_ins_en),
                .i_id         (i_id),
                .i_lat        (i_lat),
                .i_prev_take  (w_take[g-1]),
                .i_prev_entry (w_entry[g-1]),
                .o_take       (w_take[g]),
                .o_entry      (w_entry[g])
            );
        end
    end

    assign w_in_range = {1'b0, i_rank} < 7'(DEPTH);
    assign w_sel      = w_entry[i_rank[IDX_W-1:0]];

    always_comb begin
        o_entry = '0;
        if (w_in_range && w_sel.valid) begin
            o_entry = w_sel;
        end
    end

endmodule

// ===== rtl/lhts_hist.sv =====
// ----------------------------------------------------------------------------
// lhts_hist
// Histogram bins and running totals.
// ----------------------------------------------------------------------------
module lhts_hist (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rec_en,
    input  logic [15:0]       i_id,
    input  logic [31:0]       i_lat,
    input  logic              i_failed,
    input  logic [31:0]       i_bound [lhts_pkg::NUM_BOUNDS],
    input  logic [5:0]        i_bin_sel,
    output logic [63:0]       o_bin_value,
    output lhts_pkg::t_totals o_totals
);
    import lhts_pkg::*;

    logic [63:0] r_bin [NUM_BINS];
    t_totals     r_tot;
    logic [2:0]  w_bin;
    logic [NUM_BOUNDS-1:0] w_hit;

    always_comb begin
        for (int k = 0; k < NUM_BOUNDS; k++) begin
            w_hit[k] = (i_lat <= i_bound[k]);
        end
        w_bin = 3'(NUM_BINS - 1);
        // first bin whose bound holds wins
        for (int k = NUM_BOUNDS - 1; k >= 0; k--) begin
            if (w_hit[k]) begin
                w_bin = 3'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BINS; k++) begin
                r_bin[k] <= '0;
            end
            r_tot <= '0;
        end else if (i_rec_en) begin
            r_bin[w_bin]     <= r_bin[w_bin] + 64'd1;
            r_tot.calls      <= r_tot.calls + 64'd1;
            r_tot.errors     <= r_tot.errors + {63'd0, i_failed};
            r_tot.sum        <= r_tot.sum + {32'd0, i_lat};
            r_tot.recent_id  <= i_id;
            r_tot.recent_lat <= i_lat;
        end
    end

    assign o_bin_value = (i_bin_sel < 6'(NUM_BINS)) ? r_bin[i_bin_sel[2:0]] : 64'd0;
    assign o_totals    = r_tot;

endmodule

// ===== rtl/latency_histogram_topn_stats.sv =====
// ----------------------------------------------------------------------------
// latency_histogram_topn_stats
// Latency histogram, top-N latency table and running totals.
// ----------------------------------------------------------------------------
// Takes one input word per clock while input is accepted. A record word is
// classified into one of eight bins against the seven bound registers,
// updates the call/error/sum counters and the most recent entry, and is
// offered to a row of TOP_DEPTH cells holding the largest latencies in
// descending order; every cell compares its slot with the new latency in
// the same cycle and either keeps, takes the new word, or takes its upper
// neighbor's slot. A read word produces one result word, registered in a
// single output register; input is accepted whenever that register is empty
// or drained in the same cycle, so the sustained rate is one word per cycle
// as long as results are taken. Record words produce no result. The bounds
// sit on an APB port at byte addresses 0x00..0x18; pready is tied high.
// ----------------------------------------------------------------------------
module latency_histogram_topn_stats #(
    parameter int TOP_DEPTH = lhts_pkg::TOP_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  lhts_pkg::t_in_word         i_in_data,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output lhts_pkg::t_out_word        o_out_data,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lhts_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import lhts_pkg::*;

    logic [31:0]    r_bound [NUM_BOUNDS];
    logic           r_out_valid;
    t_out_word      r_out_data;
    t_out_word      n_out_data;

    logic           w_accept;
    logic           w_rec;
    logic           w_read;
    logic [CFG_IDX_W-1:0] w_cfg_idx;
    logic           w_cfg_wr;
    logic [63:0]    w_bin_value;
    t_totals        w_tot;
    t_entry         w_top;

    // ---------------- configuration port
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BOUNDS; k++) begin
                r_bound[k] <= BOUND_RESET[k];
            end
        end else if (w_cfg_wr && (w_cfg_idx < CFG_IDX_W'(NUM_BOUNDS))) begin
            r_bound[w_cfg_idx] <= pwdata;
        end
    end

    // addresses past the last bound read as zero
    assign prdata = (w_cfg_idx < CFG_IDX_W'(NUM_BOUNDS)) ? r_bound[w_cfg_idx] : 32'd0;

    // ---------------- input handshake
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_rec      = w_accept && (i_in_data.req_type == REQ_RECORD);
    assign w_read     = w_accept && (i_in_data.req_type == REQ_READ);

    // ---------------- statistics
    lhts_hist u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_en    (w_rec),
        .i_id        (i_in_data.access_id),
        .i_lat       (i_in_data.latency),
        .i_failed    (i_in_data.failed),
        .i_bound     (r_bound),
        .i_bin_sel   (i_in_data.read_index),
        .o_bin_value (w_bin_value),
        .o_totals    (w_tot)
    );

    lhts_topn #(
        .DEPTH (TOP_DEPTH)
    ) u_topn (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ins_en (w_rec),
        .i_id     (i_in_data.access_id),
        .i_lat    (i_in_data.latency),
        .i_rank   (i_in_data.read_index),
        .o_entry  (w_top)
    );

    // ---------------- read result select; unused fields stay zero
    always_comb begin
        n_out_data = '0;
        case (i_in_data.read_group)
            GRP_BIN: begin
                n_out_data.read_value = w_bin_value;
            end
            GRP_TOP: begin
                n_out_data.entry_id      = w_top.id;
                n_out_data.entry_latency = w_top.lat;
                n_out_data.entry_valid   = w_top.valid;
            end
            GRP_TOTAL: begin
                case (i_in_data.read_index)
                    TOT_CALLS:  n_out_data.read_value = w_tot.calls;
                    TOT_ERRORS: n_out_data.read_value = w_tot.errors;
                    TOT_SUM:    n_out_data.read_value = w_tot.sum;
                    TOT_RECENT: begin
                        n_out_data.entry_id      = w_tot.recent_id;
                        n_out_data.entry_latency = w_tot.recent_lat;
                    end
                    default:    n_out_data = '0;
                endcase
            end
            default: begin
                n_out_data = '0;
            end
        endcase
    end

    // ---------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_read) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_read) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== dv/lhts_stats_checker.sv =====
// ----------------------------------------------------------------------------
// lhts_stats_checker
// Watches the word channels and the APB port of the stats block, keeps its
// own copy of the histogram, top-N table and totals, and compares every
// result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module lhts_stats_checker #(
    parameter int TOP_DEPTH = lhts_pkg::TOP_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  lhts_pkg::t_in_word          i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  lhts_pkg::t_out_word         i_out_data,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [lhts_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    input  logic                        i_pready,
    output int                          o_mismatch_count,
    output int                          o_outstanding
);
    import lhts_pkg::*;

    logic [31:0] bin_bound [NUM_BOUNDS];
    logic [63:0] bin_count [NUM_BINS];
    logic [15:0] rank_id   [TOP_DEPTH];
    logic [31:0] rank_lat  [TOP_DEPTH];
    int          rank_fill;
    logic [15:0] last_id;
    logic [31:0] last_lat;
    logic [63:0] call_total;
    logic [63:0] error_total;
    logic [63:0] lat_total;

    t_out_word   pending_reads [$];
    int          mismatches = 0;

    assign o_mismatch_count = mismatches;

    task clear_stats();
        for (int k = 0; k < NUM_BOUNDS; k++) bin_bound[k] = BOUND_RESET[k];
        for (int k = 0; k < NUM_BINS; k++) bin_count[k] = '0;
        for (int k = 0; k < TOP_DEPTH; k++) begin
            rank_id[k]  = '0;
            rank_lat[k] = '0;
        end
        rank_fill   = 0;
        last_id     = '0;
        last_lat    = '0;
        call_total  = '0;
        error_total = '0;
        lat_total   = '0;
        pending_reads.delete();
    endtask

    task record_completion(input t_in_word w);
        int bin;
        int pos;
        int fill_next;
        bit take;
        bit moving;
        // first bin in index order whose bound is not exceeded
        bin = NUM_BINS - 1;
        for (int k = NUM_BOUNDS - 1; k >= 0; k--)
            if (w.latency <= bin_bound[k]) bin = k;
        bin_count[bin] += 64'd1;

        take      = 1'b1;
        pos       = 0;
        fill_next = rank_fill;
        if (rank_fill < TOP_DEPTH) begin
            pos       = rank_fill;
            fill_next = rank_fill + 1;
        end else if (w.latency > rank_lat[TOP_DEPTH-1]) begin
            pos       = TOP_DEPTH - 1;
            fill_next = TOP_DEPTH;
        end else begin
            take = 1'b0;
        end
        if (take) begin
            // stable insert: stop behind entries of equal latency
            moving = 1'b1;
            while (moving) begin
                if (pos > 0 && rank_lat[pos-1] < w.latency) begin
                    rank_lat[pos] = rank_lat[pos-1];
                    rank_id[pos]  = rank_id[pos-1];
                    pos--;
                end else begin
                    moving = 1'b0;
                end
            end
            rank_lat[pos] = w.latency;
            rank_id[pos]  = w.access_id;
            rank_fill     = fill_next;
        end

        last_id    = w.access_id;
        last_lat   = w.latency;
        call_total += 64'd1;
        if (w.failed) error_total += 64'd1;
        lat_total  += {32'd0, w.latency};
    endtask

    function t_out_word predict_read(input t_in_word w);
        t_out_word r;
        r = '0;
        case (w.read_group)
            GRP_BIN: begin
                if (w.read_index < NUM_BINS) r.read_value = bin_count[w.read_index];
            end
            GRP_TOP: begin
                if (int'(w.read_index) < rank_fill && int'(w.read_index) < TOP_DEPTH) begin
                    r.entry_id      = rank_id[w.read_index];
                    r.entry_latency = rank_lat[w.read_index];
                    r.entry_valid   = 1'b1;
                end
            end
            GRP_TOTAL: begin
                case (w.read_index)
                    TOT_CALLS:  r.read_value = call_total;
                    TOT_ERRORS: r.read_value = error_total;
                    TOT_SUM:    r.read_value = lat_total;
                    TOT_RECENT: begin
                        r.entry_id      = last_id;
                        r.entry_latency = last_lat;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word exp_word;
        bit        bad;
        if (!i_rst_n) begin
            clear_stats();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_reads.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: value=%h id=%h lat=%h valid=%b",
                                 i_out_data.read_value, i_out_data.entry_id,
                                 i_out_data.entry_latency, i_out_data.entry_valid);
                end else begin
                    exp_word = pending_reads.pop_front();
                    bad = (i_out_data.read_value    !== exp_word.read_value)    ||
                          (i_out_data.entry_id      !== exp_word.entry_id)      ||
                          (i_out_data.entry_latency !== exp_word.entry_latency) ||
                          (i_out_data.entry_valid   !== exp_word.entry_valid);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: exp value=%h id=%h lat=%h valid=%b",
                                     exp_word.read_value, exp_word.entry_id,
                                     exp_word.entry_latency, exp_word.entry_valid);
                            $display("                 got value=%h id=%h lat=%h valid=%b",
                                     i_out_data.read_value, i_out_data.entry_id,
                                     i_out_data.entry_latency, i_out_data.entry_valid);
                        end
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (int'(i_paddr[ADDR_W-1:2]) < NUM_BOUNDS)
                    bin_bound[i_paddr[ADDR_W-1:2]] = i_pwdata;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.req_type == REQ_RECORD) record_completion(i_in_data);
                else pending_reads.push_back(predict_read(i_in_data));
            end
        end
        o_outstanding <= pending_reads.size();
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the latency histogram / top-N stats block.
// ----------------------------------------------------------------------------
// A short directed run hits the bin edges, the latency extremes, ties in the
// table and every read group and selector, including the out-of-range ones.
// Random phases follow under several bound settings (reset values, all zero,
// all ones, unsorted small values, spread increasing values), with random
// idling on both channels and one long hold-off of the result side. Results
// are predicted and compared by lhts_stats_checker.
// ----------------------------------------------------------------------------
module tb;
    import lhts_pkg::*;

    // read group with no meaning; block must return all zero
    localparam logic [1:0] GRP_NONE = 2'd3;
    // idle cycles allowed after the last result before reconfiguring
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    t_in_word            in_data  = '0;
    logic                out_ready = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [31:0]         pwdata   = '0;

    logic                in_ready;
    logic                out_valid;
    t_out_word           out_data;
    logic [31:0]         prdata;
    logic                pready;

    int                  mismatch_count;
    int                  outstanding;

    // idle percentages; recv side is read by its own process, so NBA only
    int                  send_idle_pct = 22;
    int                  recv_idle_pct = 50;
    bit                  hold_go   = 1'b0;
    bit                  hold_done = 1'b0;
    int                  hold_left = 0;

    // stimulus-side copy of the bounds, used to aim latencies at bin edges
    logic [31:0]         stim_bound [NUM_BOUNDS];
    logic [31:0]         tie_lat = 32'd0;

    always #4 clk = ~clk;

    latency_histogram_topn_stats dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lhts_stats_checker checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_data        (in_data),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_data       (out_data),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_pready         (pready),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    // Result side: random stalls, plus one long hold-off when asked so the
    // output register stays full and the input side backs up.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one word; returns at the edge where it is taken. Valid stays up
    // into the next word unless a gap is drawn.
    task send_word(input t_in_word w);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        if (w.req_type == REQ_RECORD) tie_lat = w.latency;
        do @(posedge clk); while (!in_ready);
    endtask

    task send_record(input logic [15:0] id, input logic [31:0] lat, input logic fail);
        t_in_word w;
        w            = '0;
        w.req_type   = REQ_RECORD;
        w.access_id  = id;
        w.latency    = lat;
        w.failed     = fail;
        // ignored on records, so scramble them
        w.read_group = 2'($urandom);
        w.read_index = 6'($urandom);
        send_word(w);
    endtask

    task send_read(input logic [1:0] grp, input logic [5:0] idx);
        t_in_word w;
        w            = '0;
        w.req_type   = REQ_READ;
        // ignored on reads
        w.access_id  = 16'($urandom);
        w.latency    = $urandom;
        w.failed     = 1'($urandom);
        w.read_group = grp;
        w.read_index = idx;
        send_word(w);
    endtask

    function automatic logic [31:0] pick_latency();
        int k;
        case ($urandom_range(5))
            0: return 32'($urandom_range(255));
            1: begin
                // just below, on, or just above a bin edge
                k = $urandom_range(NUM_BOUNDS - 1);
                return stim_bound[k] + 32'($urandom_range(2)) - 32'd1;
            end
            2: return $urandom;
            3: return tie_lat;
            4: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
            default: return 32'hFFFF_0000 | 32'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [1:0] pick_group();
        int r;
        r = $urandom_range(99);
        if (r < 30) return GRP_BIN;
        if (r < 65) return GRP_TOP;
        if (r < 95) return GRP_TOTAL;
        return GRP_NONE;
    endfunction

    function automatic logic [5:0] pick_index();
        if ($urandom_range(99) < 85) return 6'($urandom_range(8));
        return 6'($urandom_range(63));
    endfunction

    task run_random(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 60)
                send_record(16'($urandom), pick_latency(), 1'($urandom));
            else
                send_read(pick_group(), pick_index());
        end
    endtask

    // Drop valid, wait for every predicted word, then let an in-flight
    // record settle before the APB port is touched.
    task drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup, access, then idle.
    task write_bound(input int idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < NUM_BOUNDS) stim_bound[idx] = val;
        @(posedge clk);
    endtask

    initial begin
        for (int k = 0; k < NUM_BOUNDS; k++) stim_bound[k] = BOUND_RESET[k];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed, reset bounds -------------------------------------
        // empty table and empty recent entry
        send_read(GRP_TOP, 6'd0);
        send_read(GRP_TOTAL, TOT_RECENT);
        // latency extremes, both sides of bin edges, ties, failed flag
        send_record(16'hFFFF, 32'd0, 1'b1);
        send_record(16'h0000, 32'd10, 1'b0);
        send_record(16'($urandom), 32'd11, 1'b0);
        send_record(16'($urandom), 32'd200, 1'b1);
        send_record(16'($urandom), 32'd201, 1'b0);
        send_record(16'($urandom), 32'hFFFF_FFFF, 1'b1);
        send_record(16'($urandom), 32'd50, 1'b0);
        send_record(16'($urandom), 32'd50, 1'b0);
        send_record(16'($urandom), 32'd100, 1'b0);
        // bins, including one past the last
        send_read(GRP_BIN, 6'd0);
        send_read(GRP_BIN, 6'd7);
        send_read(GRP_BIN, 6'd8);
        // table ranks: top, bottom of a full table, beyond its depth
        send_read(GRP_TOP, 6'd0);
        send_read(GRP_TOP, 6'(TOP_DEPTH_DEF - 1));
        send_read(GRP_TOP, 6'(TOP_DEPTH_DEF));
        // all totals, an unknown selector and the unused group
        send_read(GRP_TOTAL, TOT_CALLS);
        send_read(GRP_TOTAL, TOT_ERRORS);
        send_read(GRP_TOTAL, TOT_SUM);
        send_read(GRP_TOTAL, TOT_RECENT);
        send_read(GRP_TOTAL, 6'd4);
        send_read(GRP_NONE, 6'd0);
        run_random(110);
        drain();

        // ---- all bounds zero: only latency 0 lands below bin 7 ----------
        for (int k = 0; k < NUM_BOUNDS; k++) write_bound(k, 32'd0);
        // slot past the last bound register must be ignored
        write_bound(NUM_BOUNDS, 32'hDEAD_BEEF);
        run_random(80);
        drain();

        // ---- all bounds max: everything in bin 0; idling swapped --------
        send_idle_pct = 50;
        recv_idle_pct <= 22;
        for (int k = 0; k < NUM_BOUNDS; k++) write_bound(k, 32'hFFFF_FFFF);
        run_random(80);
        drain();

        // ---- unsorted small bounds, with a long result hold-off ---------
        for (int k = 0; k < NUM_BOUNDS; k++) write_bound(k, 32'($urandom_range(300)));
        hold_go <= 1'b1;
        for (int i = 0; i < 30; i++) send_read(pick_group(), pick_index());
        run_random(100);
        drain();

        // ---- increasing bounds across the full range, no idling ---------
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        for (int k = 0; k < NUM_BOUNDS; k++)
            write_bound(k, 32'(k) * 32'h2000_0000 + 32'($urandom_range(32'h1FFF_FFFF)));
        run_random(140);
        drain();

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("latency_histogram_topn_stats test passed");
        end else begin
            $display("latency_histogram_topn_stats test failed");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #(8 * 400000);
        $display("latency_histogram_topn_stats test failed");
        $finish;
    end

endmodule
